// ===== hdl/csd_pkg.sv =====
// shared types, constants and helpers for the charge session detector
// no dependencies; used by every other file of the block but csd_if
package csd_pkg;

    // default sizes handed to the top level parameters
    localparam int CHIPS_DEF = 4;
    localparam int HIST_DEF  = 8;

    // fixed field widths
    localparam int LOOP_W   = 4;
    localparam int RUN_W    = 8;
    localparam int TICK_W   = 32;
    localparam int VOLT_W   = 32;
    localparam int FRAMES_W = 20;
    localparam int LIMIT_W  = 20;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // scale factor of the minutes setting
    localparam logic [LIMIT_W-1:0] FRAME_MULT = 20'd3000;

    // loop phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_SETTLE   = 2'd1,
        PH_WAIT_END = 2'd2
    } t_phase;

    // frame mark
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_MIDDLE = 2'd2,
        KIND_LAST   = 2'd3
    } t_kind;

    // register index on the config port
    typedef enum logic [2:0] {
        REG_FINISH_VOLT = 3'd0,
        REG_RECORD_MIN  = 3'd1,
        REG_ALLOW_SEND  = 3'd2,
        REG_SETTLE      = 3'd3,
        REG_END_COUNT   = 3'd4
    } t_reg_idx;

    // per-loop state
    typedef struct packed {
        t_phase              phase;
        logic [TICK_W-1:0]   start_tick;
        logic [RUN_W-1:0]    low_run;
    } t_loop_st;

    // recording session control
    typedef struct packed {
        logic              on;
        logic [LOOP_W-1:0] loop;
    } t_sess;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [LIMIT_W-1:0] volt_limit;
        logic [LIMIT_W-1:0] frame_limit;
        logic               timeout_en;
        logic               allow_send;
        logic [15:0]        settle_ticks;
        logic [RUN_W-1:0]   end_count;
    } t_cfg;

    // one request
    typedef struct packed {
        logic [1:0]        chip_index;
        logic [2:0]        start_mask;
        logic [2:0]        volt_ok_mask;
        logic [VOLT_W-1:0] voltage_0;
        logic [VOLT_W-1:0] voltage_1;
        logic [VOLT_W-1:0] voltage_2;
        logic [TICK_W-1:0] tick_now;
        logic [2:0]        write_cycle;
    } t_item;

    // one result
    typedef struct packed {
        logic [2:0]        end_mask;
        t_kind             frame_kind;
        logic              dispatch;
        logic [LOOP_W-1:0] frame_loop;
        logic [2:0]        buffer_cycle;
        logic [1:0]        phase_index;
        logic              session_active;
    } t_res;

    // phase of a session loop: (loop + 2) mod 3
    function automatic logic [1:0] loop_phase_of(input logic [LOOP_W-1:0] loop);
        logic [1:0] ph;
        case (loop)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: ph = 2'd2;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       ph = 2'd0;
            default:                              ph = 2'd1;
        endcase
        return ph;
    endfunction

endpackage

// ===== hdl/csd_if.sv =====
// request and result channel interfaces of the charge session detector
// standalone; valid/ready handshake with flat payload fields
interface csd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  chip_index;
    logic [2:0]  start_mask;
    logic [2:0]  volt_ok_mask;
    logic [31:0] voltage_0;
    logic [31:0] voltage_1;
    logic [31:0] voltage_2;
    logic [31:0] tick_now;
    logic [2:0]  write_cycle;

    modport source (
        output valid, chip_index, start_mask, volt_ok_mask,
               voltage_0, voltage_1, voltage_2, tick_now, write_cycle,
        input  ready
    );
    modport sink (
        input  valid, chip_index, start_mask, volt_ok_mask,
               voltage_0, voltage_1, voltage_2, tick_now, write_cycle,
        output ready
    );
endinterface

interface csd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  end_mask;
    logic [1:0]  frame_kind;
    logic        dispatch;
    logic [3:0]  frame_loop;
    logic [2:0]  buffer_cycle;
    logic [1:0]  phase_index;
    logic        session_active;

    modport source (
        output valid, end_mask, frame_kind, dispatch, frame_loop,
               buffer_cycle, phase_index, session_active,
        input  ready
    );
    modport sink (
        input  valid, end_mask, frame_kind, dispatch, frame_loop,
               buffer_cycle, phase_index, session_active,
        output ready
    );
endinterface

// ===== hdl/charge_session_detect_and_frame.sv =====
// Charge session detector and frame marker.
// Request channel i_in: one service call for one sensing chip (start pulses,
// voltage readings with valid bits, tick, buffer write cycle). Result channel
// o_out: exactly one result per request (ended loops, frame mark, dispatch,
// frame loop, buffer cycle, phase, session flag). Both use valid/ready.
// Config: APB registers at byte addresses 0,4,8,12,16, to be written by the
// user only while idle; the block does not enforce this. A request lands in
// an input register; when the result register is free or being taken, one
// pass of logic reads the chip's three loop states, updates them and the
// session state, and loads the result register. Throughput: one request per
// cycle while o_out.ready is high; the next request sees each per-chip write.
// Reset (synchronous, active low): all loops idle, no session, registers at
// their defaults; requests are accepted from the first cycle after reset.
// Receiver stall: the result register holds, one more request waits in the
// input register, then i_in.ready drops until o_out.ready returns.
// depends on csd_pkg, csd_if, csd_cfg, csd_loop, csd_frame
module charge_session_detect_and_frame
    import csd_pkg::*;
#(
    parameter int CHIPS          = CHIPS_DEF,
    parameter int HISTORY_CYCLES = HIST_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    csd_in_if.sink             i_in,
    csd_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CW = (CHIPS > 1) ? $clog2(CHIPS) : 1;

    t_cfg                cfg;

    // per-chip state, shared session state and frame count
    t_loop_st            r_loop [CHIPS][3];
    logic [CHIPS-1:0]    r_chip_sending;
    t_sess               r_sess;
    logic [FRAMES_W-1:0] r_frames;

    // pipeline registers
    logic                r_in_valid;
    t_item               r_item;
    logic                r_out_valid;
    t_res                r_res;

    logic                fire;
    logic                in_range;
    logic [CW-1:0]       chip_sel;
    logic [LOOP_W-1:0]   loop_base;
    t_loop_st            cur_loop [3];
    t_loop_st            n_loop [3];
    t_sess               sess_c [4];
    logic [2:0]          ended;
    logic [VOLT_W-1:0]   volt [3];
    logic                n_sending;
    t_sess               n_sess;
    logic [FRAMES_W-1:0] n_frames;
    t_kind               kind;
    logic [3:0]          cyc_sum;
    logic [2:0]          cyc;
    t_res                n_res;

    csd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake
    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.chip_index   <= i_in.chip_index;
            r_item.start_mask   <= i_in.start_mask;
            r_item.volt_ok_mask <= i_in.volt_ok_mask;
            r_item.voltage_0    <= i_in.voltage_0;
            r_item.voltage_1    <= i_in.voltage_1;
            r_item.voltage_2    <= i_in.voltage_2;
            r_item.tick_now     <= i_in.tick_now;
            r_item.write_cycle  <= i_in.write_cycle;
        end
    end

    // chip select and its first loop number less one
    assign in_range  = (32'(r_item.chip_index) < CHIPS);
    assign chip_sel  = r_item.chip_index[CW-1:0];
    assign loop_base = {1'b0, r_item.chip_index, 1'b0} + {2'b00, r_item.chip_index};

    assign volt[0] = r_item.voltage_0;
    assign volt[1] = r_item.voltage_1;
    assign volt[2] = r_item.voltage_2;

    assign sess_c[0] = r_sess;

    // three loops of the chip, in order
    for (genvar k = 0; k < 3; k++) begin : g_loop
        assign cur_loop[k] = r_loop[chip_sel][k];

        csd_loop u_loop (
            .i_cfg      (cfg),
            .i_loop_num (loop_base + LOOP_W'(k + 1)),
            .i_start    (r_item.start_mask[k]),
            .i_volt_ok  (r_item.volt_ok_mask[k]),
            .i_voltage  (volt[k]),
            .i_tick     (r_item.tick_now),
            .i_state    (cur_loop[k]),
            .i_sess     (sess_c[k]),
            .o_state    (n_loop[k]),
            .o_sess     (sess_c[k+1]),
            .o_ended    (ended[k])
        );
    end

    csd_frame u_frame (
        .i_cfg       (cfg),
        .i_loop_base (loop_base),
        .i_sending   (r_chip_sending[chip_sel]),
        .i_sess      (sess_c[3]),
        .i_frames    (r_frames),
        .o_sending   (n_sending),
        .o_sess      (n_sess),
        .o_frames    (n_frames),
        .o_kind      (kind)
    );

    // buffer cycle two behind the write cycle, modulo the history depth
    always_comb begin
        cyc_sum = {1'b0, r_item.write_cycle} + 4'(HISTORY_CYCLES - 2);
        for (int s = 0; s < 4; s++) begin
            if (cyc_sum >= 4'(HISTORY_CYCLES)) begin
                cyc_sum = cyc_sum - 4'(HISTORY_CYCLES);
            end
        end
        cyc = cyc_sum[2:0];
    end

    // result assembly
    always_comb begin
        n_res = '0;
        if (in_range) begin
            n_res.end_mask       = ended;
            n_res.frame_kind     = kind;
            n_res.dispatch       = (kind != KIND_NONE) && cfg.allow_send;
            n_res.session_active = n_sess.on;
            if (kind != KIND_NONE) begin
                n_res.frame_loop   = sess_c[3].loop;
                n_res.buffer_cycle = cyc;
                n_res.phase_index  = loop_phase_of(sess_c[3].loop);
            end
        end else begin
            n_res.session_active = r_sess.on;
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHIPS; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r_loop[c][k] <= '{phase: PH_IDLE, start_tick: '0, low_run: '0};
                end
            end
            r_chip_sending <= '0;
            r_sess         <= '0;
            r_frames       <= '0;
        end else if (fire && in_range) begin
            for (int k = 0; k < 3; k++) begin
                r_loop[chip_sel][k] <= n_loop[k];
            end
            r_chip_sending[chip_sel] <= n_sending;
            r_sess                   <= n_sess;
            r_frames                 <= n_frames;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.end_mask       = r_res.end_mask;
    assign o_out.frame_kind     = r_res.frame_kind;
    assign o_out.dispatch       = r_res.dispatch;
    assign o_out.frame_loop     = r_res.frame_loop;
    assign o_out.buffer_cycle   = r_res.buffer_cycle;
    assign o_out.phase_index    = r_res.phase_index;
    assign o_out.session_active = r_res.session_active;

endmodule

// ===== hdl/csd_cfg.sv =====
// apb register bank of the charge session detector
// depends on csd_pkg; also keeps the scaled voltage and frame limits
module csd_cfg
    import csd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [15:0]        r_finish_voltage;
    logic [7:0]         r_record_minutes;
    logic               r_allow_send;
    logic [15:0]        r_settle_ticks;
    logic [RUN_W-1:0]   r_end_count;
    logic [LIMIT_W-1:0] r_volt_limit;
    logic [LIMIT_W-1:0] r_frame_limit;

    logic               wr_en;
    logic [2:0]         reg_idx;
    logic [LIMIT_W-1:0] n_volt_limit;
    logic [LIMIT_W-1:0] n_frame_limit;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // scaled limits: ten times the finish voltage, 3000 frames a minute less one
    assign n_volt_limit  = {1'b0, pwdata[15:0], 3'b000} + {3'b000, pwdata[15:0], 1'b0};
    assign n_frame_limit = LIMIT_W'(pwdata[7:0]) * FRAME_MULT - LIMIT_W'(1);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finish_voltage <= '0;
            r_record_minutes <= 8'd5;
            r_allow_send     <= 1'b1;
            r_settle_ticks   <= 16'd1000;
            r_end_count      <= 8'd100;
            r_volt_limit     <= '0;
            r_frame_limit    <= 20'd14999;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FINISH_VOLT: begin
                    r_finish_voltage <= pwdata[15:0];
                    r_volt_limit     <= n_volt_limit;
                end
                REG_RECORD_MIN: begin
                    r_record_minutes <= pwdata[7:0];
                    r_frame_limit    <= n_frame_limit;
                end
                REG_ALLOW_SEND: r_allow_send   <= pwdata[0];
                REG_SETTLE:     r_settle_ticks <= pwdata[15:0];
                REG_END_COUNT:  r_end_count    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_FINISH_VOLT: prdata = {16'd0, r_finish_voltage};
            REG_RECORD_MIN:  prdata = {24'd0, r_record_minutes};
            REG_ALLOW_SEND:  prdata = {31'd0, r_allow_send};
            REG_SETTLE:      prdata = {16'd0, r_settle_ticks};
            REG_END_COUNT:   prdata = {24'd0, r_end_count};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.volt_limit   = r_volt_limit;
    assign o_cfg.frame_limit  = r_frame_limit;
    assign o_cfg.timeout_en   = (r_record_minutes != 8'd0);
    assign o_cfg.allow_send   = r_allow_send;
    assign o_cfg.settle_ticks = r_settle_ticks;
    assign o_cfg.end_count    = r_end_count;

endmodule

// ===== hdl/csd_loop.sv =====
// next-state logic of one charging loop: idle, settle wait, end-of-charge wait
// depends on csd_pkg; chained three deep so session claims go in loop order
module csd_loop
    import csd_pkg::*;
(
    input  t_cfg              i_cfg,
    input  logic [LOOP_W-1:0] i_loop_num,
    input  logic              i_start,
    input  logic              i_volt_ok,
    input  logic [VOLT_W-1:0] i_voltage,
    input  logic [TICK_W-1:0] i_tick,
    input  t_loop_st          i_state,
    input  t_sess             i_sess,
    output t_loop_st          o_state,
    output t_sess             o_sess,
    output logic              o_ended
);

    logic [TICK_W-1:0] gap;
    logic [RUN_W-1:0]  run_inc;
    logic              low;

    // elapsed ticks since start, with the wrap rule of the tick counter
    always_comb begin
        if (i_tick >= i_state.start_tick) begin
            gap = i_tick - i_state.start_tick;
        end else begin
            gap = i_tick - i_state.start_tick - TICK_W'(1);
        end
    end

    assign low     = i_volt_ok && (i_voltage <= VOLT_W'(i_cfg.volt_limit));
    assign run_inc = i_state.low_run + RUN_W'(1);

    // phase transitions
    always_comb begin
        o_state = i_state;
        o_sess  = i_sess;
        o_ended = 1'b0;
        case (i_state.phase)
            PH_IDLE: begin
                if (i_start) begin
                    if (!i_sess.on) begin
                        o_sess.on   = 1'b1;
                        o_sess.loop = i_loop_num;
                    end
                    o_state.phase      = PH_SETTLE;
                    o_state.start_tick = i_tick;
                end
            end
            PH_SETTLE: begin
                if (gap >= TICK_W'(i_cfg.settle_ticks)) begin
                    o_state.phase = PH_WAIT_END;
                end
            end
            PH_WAIT_END: begin
                if (low) begin
                    o_state.low_run = run_inc;
                    if (run_inc >= i_cfg.end_count) begin
                        o_state.low_run = '0;
                        o_state.phase   = PH_IDLE;
                        o_ended         = 1'b1;
                        if (i_sess.on && (i_sess.loop == i_loop_num)) begin
                            o_sess.on = 1'b0;
                        end
                    end
                end else begin
                    o_state.low_run = '0;
                end
            end
            default: o_state.phase = PH_IDLE;
        endcase
    end

endmodule

// ===== hdl/csd_frame.sv =====
// frame marking of the chip served: first, middle and last frame with timeout
// depends on csd_pkg; works on the session state left by the loop chain
module csd_frame
    import csd_pkg::*;
(
    input  t_cfg                i_cfg,
    input  logic [LOOP_W-1:0]   i_loop_base,
    input  logic                i_sending,
    input  t_sess               i_sess,
    input  logic [FRAMES_W-1:0] i_frames,
    output logic                o_sending,
    output t_sess               o_sess,
    output logic [FRAMES_W-1:0] o_frames,
    output t_kind               o_kind
);

    logic owns;
    logic timed_out;

    // session loop belongs to this chip
    assign owns = (i_sess.loop >= i_loop_base + LOOP_W'(1))
               && (i_sess.loop <= i_loop_base + LOOP_W'(3));

    assign timed_out = i_cfg.timeout_en && (i_frames >= i_cfg.frame_limit);

    always_comb begin
        o_sending = i_sending;
        o_sess    = i_sess;
        o_frames  = i_frames;
        o_kind    = KIND_NONE;
        if (!i_sending) begin
            // waiting for the first frame of our own session
            if (i_sess.on && owns) begin
                o_kind    = KIND_FIRST;
                o_sending = 1'b1;
                o_frames  = i_frames + FRAMES_W'(1);
            end
        end else if (i_sess.on) begin
            if (timed_out) begin
                o_kind    = KIND_LAST;
                o_sess    = '0;
                o_frames  = '0;
                o_sending = 1'b0;
            end else begin
                o_kind   = KIND_MIDDLE;
                o_frames = i_frames + FRAMES_W'(1);
            end
        end else begin
            // session gone: close out
            o_kind      = KIND_LAST;
            o_sess.loop = '0;
            o_frames    = '0;
            o_sending   = 1'b0;
        end
    end

endmodule

// ===== verif/charge_session_detect_and_frame_tb.sv =====
`timescale 1ns / 1ps
// testbench for charge_session_detect_and_frame: directed and random requests, checked
// against an in-bench model of the loop, session and frame logic
// depends on csd_pkg, csd_in_if, csd_out_if and the block itself
module charge_session_detect_and_frame_tb;
    import csd_pkg::*;

    localparam int NCHIP        = CHIPS_DEF;
    localparam int NLOOP        = 3 * NCHIP;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 196;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    csd_in_if  req_ch ();
    csd_out_if res_ch ();

    charge_session_detect_and_frame DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state of the loops, the session and the frame marks
    t_phase      loop_ph   [NLOOP];
    logic [31:0] loop_t0   [NLOOP];
    logic [7:0]  loop_run  [NLOOP];
    logic        sess_on;
    logic [3:0]  sess_loop;
    logic [19:0] frame_cnt;
    logic        chip_live [NCHIP];

    // register shadow
    logic [15:0] cfg_finish;
    logic [7:0]  cfg_minutes;
    logic        cfg_allow;
    logic [15:0] cfg_settle;
    logic [7:0]  cfg_endcnt;

    t_res        result_due [$];
    t_res        rx_want;
    int          n_fail;
    int          idle_cycles;
    int          rx_hold_left;
    int          rx_gap_left;
    bit          quiet;
    logic [31:0] tick_base;

    always #1 i_clk = ~i_clk;

    // next result of the block for one request, updating the model state
    function automatic t_res charge_step(input t_item it);
        t_res        r;
        logic [2:0]  ended;
        t_kind       kind;
        logic [3:0]  floop;
        logic [2:0]  cyc;
        logic [1:0]  ph;
        logic [31:0] gap;
        logic [31:0] v;
        logic [31:0] lim;
        logic        low;
        int          cap;
        int          chip;
        int          lp;
        int          k;
        ended = 3'd0;
        kind  = KIND_NONE;
        floop = 4'd0;
        chip  = int'(it.chip_index);
        lim   = {16'd0, cfg_finish} * 32'd10;
        // three loops of the chip, in order
        for (k = 0; k < 3; k++) begin
            lp = chip * 3 + k;
            case (loop_ph[lp])
                PH_IDLE: begin
                    if (it.start_mask[k]) begin
                        if (!sess_on) begin
                            sess_on   = 1'b1;
                            sess_loop = 4'(lp + 1);
                        end
                        loop_ph[lp] = PH_SETTLE;
                        loop_t0[lp] = it.tick_now;
                    end
                end
                PH_SETTLE: begin
                    // tick wrap counts one short of a true modulo difference
                    gap = (it.tick_now >= loop_t0[lp]) ? it.tick_now - loop_t0[lp]
                        : 32'hFFFF_FFFF - loop_t0[lp] + it.tick_now;
                    if (gap >= {16'd0, cfg_settle})
                        loop_ph[lp] = PH_WAIT_END;
                end
                PH_WAIT_END: begin
                    v   = (k == 0) ? it.voltage_0 : (k == 1) ? it.voltage_1 : it.voltage_2;
                    low = it.volt_ok_mask[k] && (v <= lim);
                    if (low) begin
                        loop_run[lp] = loop_run[lp] + 8'd1;
                        if (loop_run[lp] >= cfg_endcnt) begin
                            loop_run[lp] = 8'd0;
                            if (sess_on && sess_loop == 4'(lp + 1))
                                sess_on = 1'b0;
                            loop_ph[lp] = PH_IDLE;
                            ended[k]    = 1'b1;
                        end
                    end else begin
                        loop_run[lp] = 8'd0;
                    end
                end
                default: loop_ph[lp] = PH_IDLE;
            endcase
        end
        cyc = it.write_cycle + 3'd6;
        ph  = 2'((int'(sess_loop) + 2) % 3);
        // frame marks of this chip
        if (!chip_live[chip]) begin
            if (sess_on && sess_loop >= chip * 3 + 1 && sess_loop <= chip * 3 + 3) begin
                kind            = KIND_FIRST;
                floop           = sess_loop;
                chip_live[chip] = 1'b1;
                frame_cnt       = frame_cnt + 20'd1;
            end
        end else if (sess_on) begin
            floop = sess_loop;
            cap   = 3000 * int'(cfg_minutes) - 1;
            if (cfg_minutes != 8'd0 && int'(frame_cnt) >= cap) begin
                kind            = KIND_LAST;
                sess_on         = 1'b0;
                frame_cnt       = 20'd0;
                chip_live[chip] = 1'b0;
                sess_loop       = 4'd0;
            end else begin
                kind      = KIND_MIDDLE;
                frame_cnt = frame_cnt + 20'd1;
            end
        end else begin
            kind            = KIND_LAST;
            floop           = sess_loop;
            frame_cnt       = 20'd0;
            chip_live[chip] = 1'b0;
            sess_loop       = 4'd0;
        end
        r.end_mask       = ended;
        r.frame_kind     = kind;
        r.dispatch       = (kind != KIND_NONE) && cfg_allow;
        r.frame_loop     = floop;
        r.buffer_cycle   = (kind != KIND_NONE) ? cyc : 3'd0;
        r.phase_index    = (kind != KIND_NONE) ? ph : 2'd0;
        r.session_active = sess_on;
        return r;
    endfunction

    function automatic t_item mk_item(input int chip, input logic [2:0] starts,
                                      input logic [2:0] oks, input logic [31:0] v0,
                                      input logic [31:0] v1, input logic [31:0] v2,
                                      input logic [31:0] tick, input logic [2:0] wc);
        t_item it;
        it.chip_index   = 2'(chip);
        it.start_mask   = starts;
        it.volt_ok_mask = oks;
        it.voltage_0    = v0;
        it.voltage_1    = v1;
        it.voltage_2    = v2;
        it.tick_now     = tick;
        it.write_cycle  = wc;
        return it;
    endfunction

    // random request: readings cluster around the end threshold
    function automatic t_item rand_item();
        t_item       it;
        logic [31:0] lim;
        logic [31:0] v [3];
        int          k;
        lim = {16'd0, cfg_finish} * 32'd10;
        for (k = 0; k < 3; k++) begin
            case ($urandom_range(0, 9))
                6:       v[k] = lim;
                7:       v[k] = lim + 32'd1;
                8, 9:    v[k] = $urandom;
                default: v[k] = $urandom_range(0, lim);
            endcase
        end
        case ($urandom_range(0, 63))
            0:       tick_base = $urandom;
            1:       tick_base = 32'hFFFF_FFFF - $urandom_range(0, 200);
            default: tick_base = tick_base + $urandom_range(0, 60);
        endcase
        it = mk_item($urandom_range(0, NCHIP - 1),
                     ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'd0,
                     ($urandom_range(0, 4) != 0) ? 3'd7 : 3'($urandom_range(0, 7)),
                     v[0], v[1], v[2], tick_base, 3'($urandom_range(0, 7)));
        return it;
    endfunction

    // offer one request, record its result, then maybe idle
    task automatic send_item(input t_item it);
        req_ch.valid        <= 1'b1;
        req_ch.chip_index   <= it.chip_index;
        req_ch.start_mask   <= it.start_mask;
        req_ch.volt_ok_mask <= it.volt_ok_mask;
        req_ch.voltage_0    <= it.voltage_0;
        req_ch.voltage_1    <= it.voltage_1;
        req_ch.voltage_2    <= it.voltage_2;
        req_ch.tick_now     <= it.tick_now;
        req_ch.write_cycle  <= it.write_cycle;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        result_due.push_back(charge_step(it));
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every result is back
    task automatic pause_and_drain();
        req_ch.valid <= 1'b0;
        while (result_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write followed by a read back
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] got;
        case (idx)
            REG_FINISH_VOLT, REG_SETTLE:   mask = 32'hFFFF;
            REG_RECORD_MIN, REG_END_COUNT: mask = 32'hFF;
            default:                       mask = 32'h1;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got !== (val & mask)) begin
            $error("register %0d: expected %0h, actual %0h", idx, val & mask, got);
            n_fail++;
        end
        case (idx)
            REG_FINISH_VOLT: cfg_finish  = val[15:0];
            REG_RECORD_MIN:  cfg_minutes = val[7:0];
            REG_ALLOW_SEND:  cfg_allow   = val[0];
            REG_SETTLE:      cfg_settle  = val[15:0];
            default:         cfg_endcnt  = val[7:0];
        endcase
    endtask

    task automatic write_all(input logic [31:0] fv, input logic [31:0] rm,
                             input logic [31:0] al, input logic [31:0] st,
                             input logic [31:0] ec);
        reg_write(REG_FINISH_VOLT, fv);
        reg_write(REG_RECORD_MIN, rm);
        reg_write(REG_ALLOW_SEND, al);
        reg_write(REG_SETTLE, st);
        reg_write(REG_END_COUNT, ec);
    endtask

    // reset settings: first frame, start while busy, all-ones and all-zero requests
    task automatic test_defaults();
        send_item(mk_item(0, 3'b001, 3'b000, 0, 0, 0, 32'd100, 3'd0));
        send_item(mk_item(1, 3'b111, 3'b000, 0, 0, 0, 32'd200, 3'd1));
        send_item(mk_item(0, 3'b111, 3'b111, 0, 0, 0, 32'd300, 3'd2));
        send_item(mk_item(3, 3'b111, 3'b111, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 3'd7));
        send_item(mk_item(2, 3'b000, 3'b000, 0, 0, 0, 32'd0, 3'd0));
        pause_and_drain();
    endtask

    // charge ends, invalid reading, threshold edges, session handed over within one step
    task automatic test_charge_end();
        write_all(32'hFFFF, 32'd5, 32'd1, 32'd0, 32'd1);
        send_item(mk_item(0, 3'b000, 3'b111, 0, 0, 0, 32'd400, 3'd3));
        send_item(mk_item(0, 3'b000, 3'b110, 0, 32'd655351, 32'd655350, 32'd410, 3'd4));
        send_item(mk_item(0, 3'b100, 3'b001, 32'd655350, 0, 0, 32'd420, 3'd5));
        send_item(mk_item(0, 3'b001, 3'b010, 0, 0, 0, 32'd430, 3'd6));
        send_item(mk_item(0, 3'b000, 3'b000, 0, 0, 0, 32'd440, 3'd7));
        send_item(mk_item(0, 3'b010, 3'b001, 0, 0, 0, 32'd450, 3'd0));
        send_item(mk_item(0, 3'b000, 3'b111, 0, 0, 0, 32'd460, 3'd1));
        send_item(mk_item(0, 3'b000, 3'b010, 0, 0, 0, 32'd470, 3'd2));
        pause_and_drain();
    endtask

    // zero end count ends a charge on the first low reading
    task automatic test_end_count_zero();
        reg_write(REG_END_COUNT, 32'd0);
        reg_write(REG_ALLOW_SEND, 32'd0);
        send_item(mk_item(1, 3'b000, 3'b000, 0, 0, 0, 32'd500, 3'd3));
        send_item(mk_item(1, 3'b000, 3'b111, 0, 0, 0, 32'd510, 3'd4));
        pause_and_drain();
    endtask

    // settle wait across the tick wrap, at the exact boundary
    task automatic test_tick_wrap();
        reg_write(REG_SETTLE, 32'h100);
        reg_write(REG_END_COUNT, 32'd1);
        reg_write(REG_ALLOW_SEND, 32'd1);
        send_item(mk_item(2, 3'b001, 3'b000, 0, 0, 0, 32'hFFFF_FFF0, 3'd5));
        send_item(mk_item(2, 3'b000, 3'b000, 0, 0, 0, 32'h0000_00F0, 3'd6));
        send_item(mk_item(2, 3'b000, 3'b000, 0, 0, 0, 32'h0000_00F1, 3'd7));
        send_item(mk_item(2, 3'b000, 3'b001, 0, 0, 0, 32'h0000_0100, 3'd0));
        pause_and_drain();
    endtask

    // long receiver hold fills the block, then the sender waits for every result
    task automatic test_backpressure();
        int n;
        write_all(32'd50, 32'd0, 32'd1, 32'd20, 32'd3);
        rx_hold_left = HOLD_CYCLES;
        for (n = 0; n < 30; n++) send_item(rand_item());
        pause_and_drain();
        for (n = 0; n < 30; n++) send_item(rand_item());
        pause_and_drain();
    endtask

    // random requests over several register settings; the last one runs without idling
    task automatic test_random_phases();
        logic [31:0] fv, rm, al, st, ec;
        int          ph;
        int          n;
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    fv = 32'hFFFF; rm = 32'd255; al = 32'd1; st = 32'd0; ec = 32'd1;
                end
                1: begin
                    fv = 32'd0; rm = 32'd0; al = 32'd0; st = 32'd65535; ec = 32'd255;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       fv = 32'd0;
                        1:       fv = 32'hFFFF;
                        2:       fv = $urandom_range(0, 100);
                        default: fv = $urandom_range(0, 65535);
                    endcase
                    rm = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom_range(1, 255);
                    al = $urandom_range(0, 1);
                    st = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 300);
                    case ($urandom_range(0, 7))
                        0:       ec = 32'd0;
                        1:       ec = $urandom_range(7, 255);
                        default: ec = $urandom_range(1, 6);
                    endcase
                end
            endcase
            write_all(fv, rm, al, st, ec);
            quiet = (ph == 7);
            for (n = 0; n < PHASE_ITEMS; n++) send_item(rand_item());
            pause_and_drain();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endtask

    // result check and receiver ready with random stalls and the long hold
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (result_due.size() == 0) begin
                $error("result with no request pending");
                n_fail++;
            end else begin
                rx_want = result_due.pop_front();
                check_field("end_mask", 32'(rx_want.end_mask), 32'(res_ch.end_mask));
                check_field("frame_kind", 32'(rx_want.frame_kind), 32'(res_ch.frame_kind));
                check_field("dispatch", 32'(rx_want.dispatch), 32'(res_ch.dispatch));
                check_field("frame_loop", 32'(rx_want.frame_loop), 32'(res_ch.frame_loop));
                check_field("buffer_cycle", 32'(rx_want.buffer_cycle),
                            32'(res_ch.buffer_cycle));
                check_field("phase_index", 32'(rx_want.phase_index),
                            32'(res_ch.phase_index));
                check_field("session_active", 32'(rx_want.session_active),
                            32'(res_ch.session_active));
            end
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            res_ch.ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            res_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rx_gap_left = $urandom_range(1, 16) - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // model reset, then the tests in turn
    initial begin
        int k;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.chip_index   = '0;
        req_ch.start_mask   = '0;
        req_ch.volt_ok_mask = '0;
        req_ch.voltage_0    = '0;
        req_ch.voltage_1    = '0;
        req_ch.voltage_2    = '0;
        req_ch.tick_now     = '0;
        req_ch.write_cycle  = '0;
        res_ch.ready        = 1'b0;
        n_fail              = 0;
        idle_cycles         = 0;
        rx_hold_left        = 0;
        rx_gap_left         = 0;
        quiet               = 1'b0;
        tick_base           = 32'd0;
        for (k = 0; k < NLOOP; k++) begin
            loop_ph[k]  = PH_IDLE;
            loop_t0[k]  = 32'd0;
            loop_run[k] = 8'd0;
        end
        for (k = 0; k < NCHIP; k++) chip_live[k] = 1'b0;
        sess_on     = 1'b0;
        sess_loop   = 4'd0;
        frame_cnt   = 20'd0;
        cfg_finish  = 16'd0;
        cfg_minutes = 8'd5;
        cfg_allow   = 1'b1;
        cfg_settle  = 16'd1000;
        cfg_endcnt  = 8'd100;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_charge_end();
        test_end_count_zero();
        test_tick_wrap();
        test_backpressure();
        test_random_phases();

        pause_and_drain();
        repeat (8) @(posedge i_clk);
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== charge_session_detect_and_frame.f =====
hdl/csd_pkg.sv
hdl/csd_if.sv
hdl/csd_cfg.sv
hdl/csd_loop.sv
hdl/csd_frame.sv
hdl/charge_session_detect_and_frame.sv
verif/charge_session_detect_and_frame_tb.sv
